### hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable.
`define PCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/pcc_pkg.sv
// Package with shared types and constants of the pair co-occurrence counter.
`default_nettype none
package pcc_pkg;
    localparam int VAL_W   = 8;
    localparam int DOM_W   = 9;
    localparam int OUT_W   = 24;
    localparam int ALPHA_W = 16;
    localparam int DEN_W   = 18;
    localparam int CFG_IDX_W = 1;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [OUT_W-1:0] t_out;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FMODE = 1'b1;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam t_out TOTAL_MAX = {OUT_W{1'b1}};
endpackage
`default_nettype wire

### hdl/pcc_in_if.sv
// Input channel interface carrying value and query transactions.
`default_nettype none
interface pcc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value_index;
    logic       end_of_tuple;
    logic [7:0] other_index;
    logic [8:0] domain_size_a;
    logic [8:0] domain_size_b;

    modport source(output valid, kind, value_index, end_of_tuple, other_index,
                   domain_size_a, domain_size_b, input ready);
    modport sink(input valid, kind, value_index, end_of_tuple, other_index,
                 domain_size_a, domain_size_b, output ready);
endinterface
`default_nettype wire

### hdl/pcc_out_if.sv
// Output channel interface carrying query result transactions.
`default_nettype none
interface pcc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pair_count;
    logic [23:0] min_support;
    logic        edge_res;

    modport source(output valid, pair_count, min_support, edge_res, input ready);
    modport sink(input valid, pair_count, min_support, edge_res, output ready);
endinterface
`default_nettype wire

### hdl/pcc_ram.sv
// Single-port-write, single-port-read synchronous counter memory.
`default_nettype none
module pcc_ram #(
    parameter int DEPTH = 32640,
    parameter int AW    = 15,
    parameter int DW    = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### hdl/pcc_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module pcc_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [pcc_pkg::OUT_W-1:0] i_num,
    input  wire logic [pcc_pkg::DEN_W-1:0] i_den,
    output logic                         o_done,
    output logic      [pcc_pkg::OUT_W-1:0] o_quot
);
    import pcc_pkg::*;

    logic [OUT_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[OUT_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(OUT_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[OUT_W-2:0], fits};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

### hdl/pair_cooccurrence_counter.sv
// Top level of the pair co-occurrence counter.
// Transactions arrive on i_item (valid/ready). A value transaction carries one
// value of the open tuple; end_of_tuple closes it. A query transaction names two
// values and their domain sizes and yields one result on o_res (valid/ready).
// Configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so
// only while idle, as the block does not enforce it. After reset the counter
// memory is cleared one entry per cycle, NUM_VALUES*(NUM_VALUES-1)/2 entries in
// all (32640 by default); i_item.ready stays low meanwhile. A value transaction
// passes S_SLOT, S_RD and S_WR for each earlier value of the tuple (S_SLOT alone
// when the two values are equal), as every counter update is a read-modify-write
// of the single counter memory, then S_FIN. A query passes S_QMUL, S_QRD and
// S_QOUT, waiting in S_QDIV before S_QOUT outside frequency mode for the
// bit-serial divider that computes the minimum support. The result sits in an
// output register, so the next transaction is accepted while it waits; a second
// query stalls at its last step until the receiver has taken the earlier result.
`default_nettype none
module pair_cooccurrence_counter #(
    parameter int NUM_VALUES = 256,
    parameter int MAX_ATTRS  = 8,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    pcc_in_if.sink                           i_item,
    pcc_out_if.source                        o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [pcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pcc_pkg::ALPHA_W-1:0]   i_cfg_data
);
    import pcc_pkg::*;

    localparam int PAIR_SLOTS = (NUM_VALUES * (NUM_VALUES - 1)) / 2;
    localparam int AW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int IW = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
    localparam int FW = $clog2(MAX_ATTRS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [AW:0] TWO_N_M1 = (AW + 1)'(2 * NUM_VALUES - 1);
    localparam int CMP_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SLOT = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_QMUL = 4'd6;
    localparam logic [3:0] S_QRD  = 4'd7;
    localparam logic [3:0] S_QDIV = 4'd8;
    localparam logic [3:0] S_QOUT = 4'd9;

    function automatic logic [AW-1:0] slot_of(input t_val a, input t_val b);
        logic [AW:0] lo;
        logic [AW:0] hi;
        logic [AW:0] prod;
        lo = (a < b) ? (AW + 1)'(a) : (AW + 1)'(b);
        hi = (a < b) ? (AW + 1)'(b) : (AW + 1)'(a);
        prod = lo * (TWO_N_M1 - lo);
        return AW'((prod >> 1) + hi - lo - (AW + 1)'(1));
    endfunction

    logic [3:0]            r_state;
    logic [AW-1:0]         r_clr_addr;
    logic [ALPHA_W-1:0]    r_alpha;
    logic                  r_fmode;
    t_out                  r_total;
    logic [FW-1:0]         r_fill;
    t_val                  r_tv [MAX_ATTRS];
    logic [IW-1:0]         r_k;
    t_val                  r_va;
    t_val                  r_vb;
    logic                  r_eot;
    logic [DOM_W-1:0]      r_da;
    logic [DOM_W-1:0]      r_db;
    logic [AW-1:0]         r_addr;
    logic                  r_take;
    logic                  r_pair_ok;
    t_out                  r_num;
    logic [DEN_W-1:0]      r_den;
    logic                  r_out_valid;
    t_out                  r_out_cnt;
    t_out                  r_out_min;
    logic                  r_out_edge;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  div_start;
    logic                  div_done;
    t_out                  div_quot;
    logic                  accept;
    logic                  last_k;
    t_val                  cur_a;
    logic [ALPHA_W+OUT_W-1:0] prod_at;
    logic [DOM_W-1:0]      da_eff;
    logic [DOM_W-1:0]      db_eff;
    logic [COUNT_BITS-1:0] q_count;
    t_out                  q_min;
    logic                  out_free;

    assign accept   = i_item.valid && i_item.ready;
    assign cur_a    = r_tv[r_k];
    assign last_k   = (FW'(r_k) + FW'(1)) == r_fill;
    assign prod_at  = r_alpha * r_total;
    assign da_eff   = (r_da == '0) ? DOM_W'(1) : r_da;
    assign db_eff   = (r_db == '0) ? DOM_W'(1) : r_db;
    assign q_count  = r_pair_ok ? ram_rdata : '0;
    assign q_min    = r_fmode ? r_num : div_quot;
    assign out_free = !r_out_valid || o_res.ready;

    assign ram_we    = (r_state == S_CLR) || ((r_state == S_WR) && (ram_rdata != CMAX));
    assign ram_waddr = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLR) ? '0 : ram_rdata + COUNT_BITS'(1);
    assign ram_re    = (r_state == S_RD) || (r_state == S_QRD);
    assign div_start = (r_state == S_QRD) && !r_fmode;

    pcc_ram #(
        .DEPTH(PAIR_SLOTS),
        .AW   (AW),
        .DW   (COUNT_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    pcc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_alpha     <= '0;
            r_fmode     <= 1'b0;
            r_total     <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_FMODE: r_fmode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_res.ready && (r_state != S_QOUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (32'(r_clr_addr) == PAIR_SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_va  <= i_item.value_index;
                        r_vb  <= i_item.other_index;
                        r_eot <= i_item.end_of_tuple;
                        r_da  <= i_item.domain_size_a;
                        r_db  <= i_item.domain_size_b;
                        r_k   <= '0;
                        r_take <= (32'(i_item.value_index) < NUM_VALUES)
                                  && (32'(r_fill) < MAX_ATTRS);
                        if (i_item.kind == KIND_QUERY) begin
                            r_state <= S_QMUL;
                        end else if ((32'(i_item.value_index) < NUM_VALUES)
                                     && (32'(r_fill) < MAX_ATTRS) && (r_fill != '0)) begin
                            r_state <= S_SLOT;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SLOT: begin
                    r_addr <= slot_of(cur_a, r_va);
                    if (cur_a != r_va) begin
                        r_state <= S_RD;
                    end else begin
                        r_k <= r_k + IW'(1);
                        r_state <= last_k ? S_FIN : S_SLOT;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_k <= r_k + IW'(1);
                    r_state <= last_k ? S_FIN : S_SLOT;
                end
                S_FIN: begin
                    if (r_eot) begin
                        r_fill <= '0;
                        if (r_total != TOTAL_MAX) begin
                            r_total <= r_total + OUT_W'(1);
                        end
                    end else if (r_take) begin
                        r_fill <= r_fill + FW'(1);
                    end
                    if (r_take) begin
                        r_tv[r_fill[IW-1:0]] <= r_va;
                    end
                    r_state <= S_IDLE;
                end
                S_QMUL: begin
                    r_addr    <= slot_of(r_va, r_vb);
                    r_pair_ok <= (r_va != r_vb) && (32'(r_va) < NUM_VALUES)
                                 && (32'(r_vb) < NUM_VALUES);
                    r_num     <= prod_at[ALPHA_W+OUT_W-1:ALPHA_W];
                    r_den     <= DEN_W'(da_eff) * DEN_W'(db_eff);
                    r_state   <= S_QRD;
                end
                S_QRD: begin
                    r_state <= r_fmode ? S_QOUT : S_QDIV;
                end
                S_QDIV: begin
                    if (div_done) begin
                        r_state <= S_QOUT;
                    end
                end
                S_QOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cnt   <= OUT_W'(q_count);
                        r_out_min   <= q_min;
                        r_out_edge  <= CMP_W'(q_count) >= CMP_W'(q_min);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.pair_count  = r_out_cnt;
    assign o_res.min_support = r_out_min;
    assign o_res.edge_res    = r_out_edge;
endmodule
`default_nettype wire

### hdl/pcc_checker.sv
// Port-level checker for the pair co-occurrence counter and its bind.
`default_nettype none
`include "assert_macros.svh"
module pcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [23:0] i_pair_count,
    input wire logic [23:0] i_min_support,
    input wire logic        i_edge_res
);
    `PCC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pair_count) && $stable(i_min_support), "result changed while stalled")
    `PCC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "transaction accepted while busy")
    `PCC_ASSERT(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_in_ready, "ready during memory clear")
    `PCC_ASSERT(a_edge_flag, i_clk, i_rst_n, i_out_valid && !i_edge_res |-> i_pair_count < i_min_support, "edge flag low with count at threshold")
endmodule

bind pair_cooccurrence_counter pcc_checker u_pcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_pair_count (o_res.pair_count),
    .i_min_support(o_res.min_support),
    .i_edge_res   (o_res.edge_res)
);
`default_nettype wire
